// ===== hdl/u8vd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8vd_pkg
// Shared types and constants of the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package u8vd_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] E0_LO       = 8'hA0;
    localparam logic [7:0] ED_HI       = 8'h9F;
    localparam logic [7:0] F0_LO       = 8'h90;
    localparam logic [7:0] F4_HI       = 8'h8F;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] LEAD_C0     = 8'hC0;
    localparam logic [7:0] LEAD_C1     = 8'hC1;
    localparam logic [7:0] END_OF_TEXT = 8'h00;

    // Results caused by one input byte: some replacements for a broken
    // sequence, then at most one result from the byte itself.
    typedef struct packed {
        logic [1:0]      flush;
        logic            fin_valid;
        logic [CP_W-1:0] fin_cp;
        logic            fin_rep;
    } burst_t;

endpackage
`default_nettype wire

// ===== hdl/u8vd_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8vd_decoder
// Sequence state and the per-byte decode that yields the result burst.
// ----------------------------------------------------------------------------
module u8vd_decoder (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [7:0]      in_byte,
    input  wire logic            accept,
    output u8vd_pkg::burst_t     burst
);

    logic [7:0]                lead_reg, lead_next;
    logic [1:0]                need_reg, need_next;
    logic [1:0]                taken_reg, taken_next;
    logic [u8vd_pkg::CP_W-1:0] pv_reg, pv_next;

    logic [7:0]                lo;
    logic [7:0]                hi;
    logic                      never_ok;
    logic                      in_range;
    logic [u8vd_pkg::CP_W-1:0] pv_ext;
    logic [1:0]                taken_inc;
    logic                      bad_val;
    logic                      do_lead;

    always_comb begin
        lo       = u8vd_pkg::CONT_LO;
        hi       = u8vd_pkg::CONT_HI;
        never_ok = 1'b0;
        if (taken_reg == 2'd0) begin
            if (need_reg == 2'd1) begin
                never_ok = lead_reg inside {u8vd_pkg::LEAD_C0, u8vd_pkg::LEAD_C1};
            end else if (lead_reg == u8vd_pkg::LEAD_E0) begin
                lo = u8vd_pkg::E0_LO;
            end else if (lead_reg == u8vd_pkg::LEAD_ED) begin
                hi = u8vd_pkg::ED_HI;
            end else if (lead_reg == u8vd_pkg::LEAD_F0) begin
                lo = u8vd_pkg::F0_LO;
            end else if (lead_reg == u8vd_pkg::LEAD_F4) begin
                hi = u8vd_pkg::F4_HI;
            end
        end
        in_range  = !never_ok && (in_byte >= lo) && (in_byte <= hi);
        pv_ext    = {pv_reg[u8vd_pkg::CP_W-7:0], in_byte[5:0]};
        taken_inc = taken_reg + 2'd1;
        bad_val   = (pv_ext > u8vd_pkg::MAX_SCALAR) ||
                    ((pv_ext >= u8vd_pkg::SURR_LO) && (pv_ext <= u8vd_pkg::SURR_HI));
        do_lead   = (need_reg == 2'd0) || !in_range;
    end

    always_comb begin
        lead_next       = lead_reg;
        need_next       = need_reg;
        taken_next      = taken_reg;
        pv_next         = pv_reg;
        burst.flush     = 2'd0;
        burst.fin_valid = 1'b0;
        burst.fin_cp    = u8vd_pkg::REPL_CHAR;
        burst.fin_rep   = 1'b1;
        if (!do_lead) begin
            if (taken_inc == need_reg) begin
                burst.fin_valid = 1'b1;
                burst.fin_cp    = bad_val ? u8vd_pkg::REPL_CHAR : pv_ext;
                burst.fin_rep   = bad_val;
                lead_next       = 8'd0;
                need_next       = 2'd0;
                taken_next      = 2'd0;
                pv_next         = '0;
            end else begin
                taken_next = taken_inc;
                pv_next    = pv_ext;
            end
        end else begin
            if (need_reg != 2'd0) begin
                burst.flush = taken_inc;
            end
            lead_next  = 8'd0;
            need_next  = 2'd0;
            taken_next = 2'd0;
            pv_next    = '0;
            if (in_byte == u8vd_pkg::END_OF_TEXT) begin
                burst.fin_valid = 1'b0;
            end else if (!in_byte[7]) begin
                burst.fin_valid = 1'b1;
                burst.fin_cp    = {13'd0, in_byte};
                burst.fin_rep   = 1'b0;
            end else if (in_byte[7:5] == 3'b110) begin
                lead_next = in_byte;
                pv_next   = {16'd0, in_byte[4:0]};
                need_next = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
                lead_next = in_byte;
                pv_next   = {17'd0, in_byte[3:0]};
                need_next = 2'd2;
            end else if (in_byte[7:3] == 5'b11110) begin
                lead_next = in_byte;
                pv_next   = {18'd0, in_byte[2:0]};
                need_next = 2'd3;
            end else begin
                burst.fin_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg  <= 8'd0;
            need_reg  <= 2'd0;
            taken_reg <= 2'd0;
            pv_reg    <= '0;
        end else if (accept) begin
            lead_reg  <= lead_next;
            need_reg  <= need_next;
            taken_reg <= taken_next;
            pv_reg    <= pv_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/u8vd_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8vd_sequencer
// Result register that holds one burst and sends its results one per transfer.
// ----------------------------------------------------------------------------
module u8vd_sequencer (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      load,
    input  u8vd_pkg::burst_t               burst,
    output logic                           room,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [u8vd_pkg::CP_W-1:0]      m_code_point,
    output logic                           m_replaced,
    output logic                           m_last
);

    logic [1:0]                flush_reg, flush_next;
    logic                      fin_valid_reg, fin_valid_next;
    logic [u8vd_pkg::CP_W-1:0] cp_reg;
    logic                      rep_reg;
    logic                      take;

    always_comb begin
        m_valid = (flush_reg != 2'd0) || fin_valid_reg;
        if (flush_reg != 2'd0) begin
            m_code_point = u8vd_pkg::REPL_CHAR;
            m_replaced   = 1'b1;
            m_last       = (flush_reg == 2'd1) && !fin_valid_reg;
        end else begin
            m_code_point = cp_reg;
            m_replaced   = rep_reg;
            m_last       = 1'b1;
        end
        take = m_valid && m_ready;
        room = !m_valid || (m_ready && m_last);
    end

    always_comb begin
        flush_next     = flush_reg;
        fin_valid_next = fin_valid_reg;
        if (load) begin
            flush_next     = burst.flush;
            fin_valid_next = burst.fin_valid;
        end else if (take) begin
            if (flush_reg != 2'd0) begin
                flush_next = flush_reg - 2'd1;
            end else begin
                fin_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_reg     <= 2'd0;
            fin_valid_reg <= 1'b0;
        end else begin
            flush_reg     <= flush_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg  <= burst.fin_cp;
            rep_reg <= burst.fin_rep;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result register not empty after reset.");

    a_load_only_with_room: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> room)
        else $error("Burst loaded over pending results.");

    a_flush_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && flush_reg != 2'd0 && !load) |=> flush_reg == $past(flush_reg) - 2'd1)
        else $error("Replacement count did not step down on a transfer.");

    a_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(flush_reg) && $stable(fin_valid_reg)))
        else $error("Pending burst changed while stalled.");

    a_last_no_more: assert property (@(posedge aclk) disable iff (!aresetn)
        m_last |-> (flush_reg == 2'd0 || (flush_reg == 2'd1 && !fin_valid_reg)))
        else $error("Last flag raised with results still pending.");

endmodule
`default_nettype wire

// ===== hdl/utf8_validating_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// Decodes a UTF-8 byte stream into code points, replacing errors with U+FFFD.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                               Handshake
//  s_       in         in_byte[7:0]                          s_valid / s_ready
//  m_       out        code_point[20:0], replaced, last      m_valid / m_ready
//
//  A byte is decoded in the cycle it is transferred and its results land in
//  the result register; each result then takes one output transfer.
//  Bytes that cause zero or one result sustain one byte per cycle while
//  m_ready stays high. A broken sequence causes up to four results, and
//  the input waits until the last of them is being transferred.
//  Reset is synchronous and active low and returns the decoder to idle.
// ----------------------------------------------------------------------------
module utf8_validating_decoder (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_in_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [20:0]               m_code_point,
    output logic                      m_replaced,
    output logic                      m_last
);

    u8vd_pkg::burst_t burst;
    logic             room;
    logic             load;

    assign s_ready = room;
    assign load    = s_valid && room;

    u8vd_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (s_in_byte),
        .accept  (load),
        .burst   (burst)
    );

    u8vd_sequencer u_sequencer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .burst        (burst),
        .room         (room),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_replaced   (m_replaced),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire
